// File: rtl/voice_mix_scale_clamp_assert.svh
// Assertion macros used by the voice mixer back end
`ifndef VOICE_MIX_SCALE_CLAMP_ASSERT_SVH
`define VOICE_MIX_SCALE_CLAMP_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define VMSC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice mixer assertion failed");

// next-cycle implication, checked on clk outside reset
`define VMSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice mixer assertion failed");

`endif

// File: rtl/vmsc_pkg.sv
// Shared constants and types of the voice mixer
package vmsc_pkg;

  localparam int MAX_VOICES  = 8;
  localparam int VOICE_CNT_W = $clog2(MAX_VOICES + 1);

  localparam int SUM_W       = 20;
  localparam int MASTER_W    = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_OUTPUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_OUTPUT   = 2'd2;

  localparam logic [MASTER_W-1:0] MASTER_RESET = 9'd256;

  // one classified voice, volumes already stripped of their low three bits
  typedef struct packed {
    logic signed [7:0] sample;
    logic [4:0]        left_vol;
    logic [4:0]        right_vol;
    logic              add;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic [MASTER_W-1:0] master_volume;
    logic                wide_output;
    logic                mono_output;
  } cfg_t;

endpackage

// File: rtl/voice_mix_scale_clamp.sv
// Top level of the saturating voice mixer with master scaling
//
// Voices enter on in_valid/in_ready, one per transfer: sample, left_volume,
// right_volume and last_voice. A voice with last_voice set closes the slot;
// the mixed pair then leaves on out_valid/out_ready as left_out/right_out.
// Voices without last_voice produce no transfer on the output channel.
// Voices are accepted one per cycle while the queue is not full; a voice
// that closes a slot takes the mixing unit through its accumulate, master
// multiply and format states, set by the sequencer of the back end, before
// the mix reaches the output register and out_valid.
// A two-entry queue separates input acceptance from mixing, so voices keep
// flowing while a finished mix waits in the output register. If the
// receiver stalls, the mix holds, the queue fills and in_ready drops.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 master
// volume, 1 wide output, 2 mono output) at once; write only while idle.
// Reset (rst, synchronous): running sums and voice count cleared, queue and
// output emptied, master volume 256, byte stereo output.
module voice_mix_scale_clamp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vmsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vmsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [7:0]                   sample,
  input  logic [7:0]                          left_volume,
  input  logic [7:0]                          right_volume,
  input  logic                                last_voice,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  left_out,
  output logic signed [15:0]                  right_out
);

  vmsc_pkg::cfg_t   cfg;
  vmsc_pkg::entry_t push_data;
  vmsc_pkg::entry_t pop_data;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master_volume <= vmsc_pkg::MASTER_RESET;
      cfg.wide_output   <= 1'b0;
      cfg.mono_output   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        vmsc_pkg::REG_MASTER_VOLUME: cfg.master_volume <= cfg_data[vmsc_pkg::MASTER_W-1:0];
        vmsc_pkg::REG_WIDE_OUTPUT:   cfg.wide_output   <= cfg_data[0];
        vmsc_pkg::REG_MONO_OUTPUT:   cfg.mono_output   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vmsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .left_volume  (left_volume),
    .right_volume (right_volume),
    .last_voice   (last_voice),
    .q_full       (full),
    .q_push       (push),
    .q_data       (push_data)
  );

  vmsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  vmsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

// File: rtl/vmsc_front.sv
// Front end: accepts voices, tracks voice slots, classifies each voice
module vmsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [7:0]     sample,
  input  logic [7:0]            left_volume,
  input  logic [7:0]            right_volume,
  input  logic                  last_voice,
  input  logic                  q_full,
  output logic                  q_push,
  output vmsc_pkg::entry_t      q_data
);

  logic [vmsc_pkg::VOICE_CNT_W-1:0] voices_used;
  logic [vmsc_pkg::VOICE_CNT_W-1:0] voices_used_next;
  logic                             take;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign take = ((left_volume != 8'd0) || (right_volume != 8'd0)) &&
                (voices_used < vmsc_pkg::VOICE_CNT_W'(vmsc_pkg::MAX_VOICES));

  always_comb begin
    q_data.sample    = sample;
    q_data.left_vol  = left_volume[7:3];
    q_data.right_vol = right_volume[7:3];
    q_data.add       = take;
    q_data.last      = last_voice;
  end

  always_comb begin
    voices_used_next = voices_used;
    if (q_push) begin
      if (last_voice) begin
        voices_used_next = '0;
      end else if (take) begin
        voices_used_next = voices_used + vmsc_pkg::VOICE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voices_used <= '0;
    end else begin
      voices_used <= voices_used_next;
    end
  end

endmodule

// File: rtl/vmsc_queue.sv
// Short queue between the front end and the mixing back end
module vmsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vmsc_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output vmsc_pkg::entry_t pop_data,
  output logic             empty
);

  vmsc_pkg::entry_t                 mem [vmsc_pkg::QUEUE_DEPTH];
  logic [vmsc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [vmsc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [vmsc_pkg::QUEUE_CNT_W-1:0] count;

  assign full     = (count == vmsc_pkg::QUEUE_CNT_W'(vmsc_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + vmsc_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + vmsc_pkg::QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + vmsc_pkg::QUEUE_CNT_W'(1);
        2'b01:   count <= count - vmsc_pkg::QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/vmsc_back.sv
// Back end: multiply-accumulate, master scaling, clamping and output register
`include "voice_mix_scale_clamp_assert.svh"

module vmsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  vmsc_pkg::entry_t    q_data,
  output logic                q_pop,
  input  vmsc_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  left_out,
  output logic signed [15:0]  right_out
);

  typedef enum logic [1:0] {S_ACC, S_MUL, S_OUT} state_t;

  state_t                           state;
  logic signed [vmsc_pkg::SUM_W-1:0] left_sum;
  logic signed [vmsc_pkg::SUM_W-1:0] right_sum;
  logic signed [29:0]               left_prod;
  logic signed [29:0]               right_prod;

  logic signed [13:0]               left_mac;
  logic signed [13:0]               right_mac;
  logic signed [vmsc_pkg::SUM_W-1:0] left_sum_next;
  logic signed [vmsc_pkg::SUM_W-1:0] right_sum_next;
  logic signed [15:0]               left_fmt;
  logic signed [15:0]               right_fmt;
  logic                             load_out;

  function automatic logic signed [vmsc_pkg::SUM_W-1:0] sat_add(
    input logic signed [vmsc_pkg::SUM_W-1:0] acc,
    input logic signed [13:0]                mac,
    input logic                              en
  );
    logic signed [vmsc_pkg::SUM_W:0] s;
    s = {acc[vmsc_pkg::SUM_W-1], acc} +
        (en ? {{(vmsc_pkg::SUM_W - 16){mac[13]}}, mac, 3'b000} : '0);
    if (s[vmsc_pkg::SUM_W] != s[vmsc_pkg::SUM_W-1]) begin
      return s[vmsc_pkg::SUM_W] ? {1'b1, {(vmsc_pkg::SUM_W - 1){1'b0}}}
                                : {1'b0, {(vmsc_pkg::SUM_W - 1){1'b1}}};
    end
    return s[vmsc_pkg::SUM_W-1:0];
  endfunction

  // floor shift by 8, clamp to 16 bits, then pick wide or offset-byte format
  function automatic logic signed [15:0] finish(
    input logic signed [29:0] p,
    input logic               wide
  );
    logic signed [21:0] v;
    logic signed [15:0] c;
    v = p[29:8];
    if (v[21:15] != {7{v[21]}}) begin
      c = v[21] ? 16'sh8000 : 16'sh7fff;
    end else begin
      c = v[15:0];
    end
    return wide ? c : {8'h00, ~c[15], c[14:8]};
  endfunction

  assign left_mac  = q_data.sample * $signed({1'b0, q_data.left_vol});
  assign right_mac = q_data.sample * $signed({1'b0, q_data.right_vol});

  assign left_sum_next  = sat_add(left_sum, left_mac, q_data.add);
  assign right_sum_next = sat_add(right_sum, right_mac, q_data.add);

  assign q_pop    = (state == S_ACC) && !q_empty;
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  assign left_fmt  = finish(left_prod, cfg.wide_output);
  assign right_fmt = cfg.mono_output ? 16'sd0 : finish(right_prod, cfg.wide_output);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      left_sum  <= '0;
      right_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACC: begin
          if (q_pop) begin
            left_sum  <= left_sum_next;
            right_sum <= right_sum_next;
            if (q_data.last) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          left_prod  <= left_sum * $signed({1'b0, cfg.master_volume});
          right_prod <= right_sum * $signed({1'b0, cfg.master_volume});
          left_sum   <= '0;
          right_sum  <= '0;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            left_out  <= left_fmt;
            right_out <= right_fmt;
            state     <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  `VMSC_ASSERT_SAME(a_pop_only_acc, q_pop, state == S_ACC)
  `VMSC_ASSERT_NEXT(a_mul_clears, state == S_MUL,
                    left_sum == '0 && right_sum == '0 && state == S_OUT)
  `VMSC_ASSERT_NEXT(a_last_goes_mul, q_pop && q_data.last, state == S_MUL)
  `VMSC_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid && state == S_ACC)

endmodule

// File: sim/voice_mix_scale_clamp_test.sv
// Self-checking testbench for the saturating voice mixer voice_mix_scale_clamp
`timescale 1ns / 100ps

module voice_mix_scale_clamp_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_VOICES = 750;
  localparam int SUM_HI = (1 << (vmsc_pkg::SUM_W - 1)) - 1;
  localparam int SUM_LO = -(1 << (vmsc_pkg::SUM_W - 1));

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } mix_t;

  class mix_scoreboard;
    logic [vmsc_pkg::MASTER_W-1:0] master_volume;
    bit wide_output;
    bit mono_output;
    int left_sum;
    int right_sum;
    int voices_used;
    int errors;
    mix_t pending_mixes[$];

    function new();
      errors = 0;
      master_volume = vmsc_pkg::MASTER_RESET;
      wide_output = 1'b0;
      mono_output = 1'b0;
      left_sum = 0;
      right_sum = 0;
      voices_used = 0;
    endfunction

    function void write_reg(logic [vmsc_pkg::CFG_IDX_W-1:0] index,
                            logic [vmsc_pkg::CFG_DATA_W-1:0] data);
      case (index)
        vmsc_pkg::REG_MASTER_VOLUME: master_volume = data[vmsc_pkg::MASTER_W-1:0];
        vmsc_pkg::REG_WIDE_OUTPUT: wide_output = data[0];
        vmsc_pkg::REG_MONO_OUTPUT: mono_output = data[0];
        default: ;
      endcase
    endfunction

    function int add_clamped(int acc, int term);
      int s;
      s = acc + term;
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      return s;
    endfunction

    // master gain, floor shift by 8, clamp to 16 bits, then output format
    function logic [15:0] scale_and_format(int acc);
      longint scaled;
      longint level;
      longint byte_level;
      scaled = longint'(acc) * longint'(master_volume);
      level = scaled >>> 8;
      if (level > 32767) level = 32767;
      if (level < -32768) level = -32768;
      if (wide_output) return level[15:0];
      byte_level = (level >>> 8) + 128;
      return byte_level[15:0];
    endfunction

    function void note_voice(logic signed [7:0] smp, logic [7:0] lv, logic [7:0] rv,
                             logic last);
      mix_t m;
      if ((lv != 0 || rv != 0) && voices_used < vmsc_pkg::MAX_VOICES) begin
        voices_used++;
        left_sum = add_clamped(left_sum, int'(smp) * int'(lv & 8'hf8));
        right_sum = add_clamped(right_sum, int'(smp) * int'(rv & 8'hf8));
      end
      if (last) begin
        m.left = scale_and_format(left_sum);
        m.right = mono_output ? 16'sd0 : scale_and_format(right_sum);
        pending_mixes.push_back(m);
        left_sum = 0;
        right_sum = 0;
        voices_used = 0;
      end
    endfunction

    function void check_mix(logic signed [15:0] left, logic signed [15:0] right);
      mix_t m;
      if (pending_mixes.size() == 0) begin
        $error("output transfer with no mix expected: left_out %0d right_out %0d",
               left, right);
        errors++;
        return;
      end
      m = pending_mixes.pop_front();
      if (left !== m.left) begin
        $error("left_out: expected %0d, actual %0d", m.left, left);
        errors++;
      end
      if (right !== m.right) begin
        $error("right_out: expected %0d, actual %0d", m.right, right);
        errors++;
      end
    endfunction

    function int pending();
      return pending_mixes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [vmsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vmsc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [7:0] sample;
  logic [7:0] left_volume;
  logic [7:0] right_volume;
  logic last_voice;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  mix_scoreboard mixer;
  bit rst_done = 1'b0;
  bit steady = 1'b0;
  int voices_sent = 0;
  int cycle_count = 0;

  voice_mix_scale_clamp uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .left_volume(left_volume),
    .right_volume(right_volume),
    .last_voice(last_voice),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out(left_out),
    .right_out(right_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // all tasks below start and end at a falling edge
  task automatic write_reg(input logic [vmsc_pkg::CFG_IDX_W-1:0] index,
                           input int unsigned data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data[vmsc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    mixer.write_reg(index, cfg_data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_mode(input int unsigned master, input bit wide, input bit mono);
    write_reg(vmsc_pkg::REG_MASTER_VOLUME, master);
    write_reg(vmsc_pkg::REG_WIDE_OUTPUT, wide);
    write_reg(vmsc_pkg::REG_MONO_OUTPUT, mono);
  endtask

  task automatic send_voice(input logic signed [7:0] smp, input logic [7:0] lv,
                            input logic [7:0] rv, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = smp;
    left_volume = lv;
    right_volume = rv;
    last_voice = last;
    do @(posedge clk); while (!in_ready);
    mixer.note_voice(smp, lv, rv, last);
    voices_sent++;
    @(negedge clk);
  endtask

  // stop sending, wait for every mix, then let the pipeline empty
  task automatic settle();
    in_valid = 1'b0;
    while (mixer.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_slot(input int count);
    logic signed [7:0] smp;
    logic [7:0] lv;
    logic [7:0] rv;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: smp = -8'sd128;
        1: smp = 8'sd127;
        2: smp = 8'sd0;
        default: smp = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0: begin
          lv = 8'd0;
          rv = 8'd0;
        end
        1: begin
          lv = 8'($urandom_range(0, 7));
          rv = 8'($urandom_range(0, 7));
        end
        2: begin
          lv = 8'd255;
          rv = $urandom_range(0, 1) ? 8'd255 : 8'd248;
        end
        default: begin
          lv = 8'($urandom_range(0, 255));
          rv = 8'($urandom_range(0, 255));
        end
      endcase
      send_voice(smp, lv, rv, i == count - 1);
    end
  endtask

  function automatic int unsigned pick_master();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 255;
      3: return 256;
      4: return 257;
      5: return 511;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  initial begin
    int phase_end;
    mixer = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = vmsc_pkg::REG_MASTER_VOLUME;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    left_volume = '0;
    right_volume = '0;
    last_voice = 1'b0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    rst_done = 1'b1;

    // reset configuration: master unity, byte stereo
    send_voice(8'sd127, 8'd255, 8'd255, 1'b1);
    send_voice(-8'sd128, 8'd255, 8'd0, 1'b0);
    send_voice(8'sd0, 8'd0, 8'd0, 1'b0);
    send_voice(8'sd5, 8'd7, 8'd3, 1'b0);
    send_voice(-8'sd128, 8'd248, 8'd248, 1'b1);
    settle();

    // voices past the limit are dropped; silent closing voice
    set_mode(256, 1'b1, 1'b0);
    for (int i = 0; i < 10; i++) send_voice(8'sd127, 8'd255, 8'd255, i == 9);
    send_voice(8'sd100, 8'd0, 8'd0, 1'b1);
    settle();

    // gain above unity drives the output into the 16-bit clamp, mono
    set_mode(511, 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) send_voice(-8'sd128, 8'd255, 8'd255, i == 3);
    settle();

    set_mode(0, 1'b1, 1'b0);
    send_voice(8'sd127, 8'd255, 8'd255, 1'b1);
    settle();

    // mono in byte format; unused register index has no effect
    set_mode(256, 1'b0, 1'b1);
    write_reg(2'd3, 9'h1ff);
    send_voice(-8'sd1, 8'd8, 8'd255, 1'b1);
    send_voice(8'sd127, 8'd255, 8'd8, 1'b1);

    voices_sent = 0;
    while (voices_sent < RANDOM_VOICES) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      set_mode(pick_master(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      phase_end = voices_sent + $urandom_range(60, 120);
      while (voices_sent < phase_end)
        send_slot(($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8));
    end
    settle();

    if (mixer.errors == 0 && mixer.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // output side: random stall before each transfer, none in steady phases
  initial begin
    int stall;
    wait (rst_done);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      mixer.check_mix(left_out, right_out);
      @(negedge clk);
    end
  end

endmodule
